// File: hdl/vblank_interval_statistics_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vblank interval statistics block
// ----------------------------------------------------------------------------
`ifndef VBLANK_INTERVAL_STATISTICS_MACROS_SVH
`define VBLANK_INTERVAL_STATISTICS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VIS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vis assertion failed");
// next-cycle implication
`define VIS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vis assertion failed");
`else
`define VIS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define VIS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/vis_pkg.sv
// ----------------------------------------------------------------------------
// vis_pkg
// Shared types and constants of the vblank interval statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vis_pkg;

    localparam int TS_W    = 64;
    localparam int DELTA_W = 32;
    localparam int MED_W   = 33;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    // op codes on the input stream
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // command kinds after classification
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [30:0] RATE_NUM = 31'd2000000000;

    typedef struct packed {
        logic [1:0]      kind;
        logic [TS_W-1:0] stamp;
    } cmd_t;

    typedef struct packed {
        logic        overflowed;
        logic [31:0] reset_total;
        logic        rate_valid;
        logic [29:0] rate_millihertz;
        logic [32:0] median_delta;
        logic [39:0] mean_delta;
        logic [31:0] max_delta;
        logic [31:0] min_delta;
        logic [9:0]  delta_count;
        logic [63:0] last_time;
        logic [63:0] first_time;
        logic [10:0] sample_count;
    } result_t;

endpackage
`default_nettype wire

// File: hdl/vis_ram.sv
// ----------------------------------------------------------------------------
// vis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vis_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1023,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/vis_div.sv
// ----------------------------------------------------------------------------
// vis_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vis_div #(
    parameter int NW = 51,
    parameter int DW = 33
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    // trial subtraction of the divisor from the shifted remainder
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// File: hdl/vis_front.sv
// ----------------------------------------------------------------------------
// vis_front
// Accepts input transactions, classifies the op and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vis_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [63:0]   s_axis_tdata,  // timestamp
    input  wire logic [1:0]    s_axis_tuser,  // op
    input  wire logic          pop,
    output logic               head_valid,
    output vis_pkg::cmd_t      head
);

    import vis_pkg::*;

    cmd_t           q_reg [QDEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           accept;
    logic           push;
    logic [1:0]     kind;
    logic           known;

    // classify the op; the unused code is dropped here
    always_comb
    begin
        kind  = KIND_RECORD;
        known = 1'b1;
        case (s_axis_tuser)
            OP_RECORD: kind = KIND_RECORD;
            OP_REPORT: kind = KIND_REPORT;
            OP_CLEAR:  kind = KIND_CLEAR;
            default:   known = 1'b0;
        endcase
    end

    assign s_axis_tready = cnt_reg != (QAW+1)'(QDEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && known;
    assign head_valid    = cnt_reg != '0;
    assign head          = q_reg[rp_reg];

    // queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{kind: kind, stamp: s_axis_tdata};
        end
    end

endmodule
`default_nettype wire

// File: hdl/vis_back.sv
// ----------------------------------------------------------------------------
// vis_back
// Executes queued commands: series update, clear and report generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vis_back #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire vis_pkg::cmd_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output vis_pkg::result_t     result
);

    import vis_pkg::*;

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int DEPTH = MAX_SAMPLES - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = DELTA_W + CW;
    localparam int NW    = SW + 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GAP  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_MEAN = 3'd4;
    localparam logic [2:0] S_RATE = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]         state_reg;
    logic [TS_W-1:0]    stamp_reg;
    logic [TS_W-1:0]    first_reg;
    logic [TS_W-1:0]    last_reg;
    logic [CW-1:0]      count_reg;
    logic [SW-1:0]      sum_reg;
    logic [DELTA_W-1:0] min_reg;
    logic [DELTA_W-1:0] max_reg;
    logic [31:0]        resets_reg;
    logic               ovf_reg;
    logic [DELTA_W-1:0] gap_reg;
    logic               zero_reg;
    logic               gt_reg;
    logic               lt_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      c_reg;
    logic [CW-1:0]      iss_reg;
    logic               pend_reg;
    logic [DELTA_W-1:0] prefix_reg;
    logic [DELTA_W-1:0] himask_reg;
    logic [4:0]         bit_reg;
    logic               pass_reg;
    logic [DELTA_W-1:0] sel_a_reg;
    logic [MED_W-1:0]   med_reg;
    logic [39:0]        mean_reg;
    logic [29:0]        rate_reg;
    logic               div_start_reg;
    logic               out_valid_reg;
    result_t            result_reg;

    logic [TS_W-1:0]    gap_full;
    logic [CW-1:0]      n_comb;
    logic [CW-1:0]      wr_idx;
    logic               ram_we;
    logic               ram_re;
    logic [DELTA_W-1:0] ram_rdata;
    logic               match;
    logic               pass_end;
    logic               take_one;
    logic [DELTA_W-1:0] sel_val;
    logic [NW-1:0]      div_num;
    logic [MED_W-1:0]   div_den;
    logic               div_done;
    logic [NW-1:0]      div_quo;

    // command pop: a report waits for the output register to drain
    assign pop = (state_reg == S_IDLE) && head_valid
                 && ((head.kind != KIND_REPORT) || !out_valid_reg);

    assign gap_full = stamp_reg - last_reg;
    assign n_comb   = (count_reg > CW'(1)) ? count_reg - 1'b1 : '0;
    assign wr_idx   = count_reg - 1'b1;

    // delta store write on an accepted increasing stamp
    assign ram_we = (state_reg == S_UPD) && !zero_reg && (count_reg != '0)
                    && gt_reg && (count_reg < CW'(MAX_SAMPLES));
    assign ram_re = (state_reg == S_SEL) && (iss_reg < n_reg);

    vis_ram #(
        .WIDTH (DELTA_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_idx[AW-1:0]),
        .wdata(gap_reg),
        .re   (ram_re),
        .raddr(iss_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    // bitwise selection: count entries matching the prefix with a zero here
    assign match    = (((ram_rdata ^ prefix_reg) & himask_reg) == '0) && !ram_rdata[bit_reg];
    assign pass_end = (state_reg == S_SEL) && (iss_reg == n_reg) && !pend_reg;
    assign take_one = !(k_reg < c_reg);
    assign sel_val  = prefix_reg | (take_one ? (DELTA_W'(1) << bit_reg) : '0);

    // shared divider: mean first, then rate
    assign div_num = (state_reg == S_RATE) ? NW'(RATE_NUM) : {sum_reg, 8'd0};
    assign div_den = (state_reg == S_RATE) ? med_reg : MED_W'(n_reg);

    vis_div #(
        .NW(NW),
        .DW(MED_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start_reg),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_quo)
    );

    // divider start pulses: mean after the last selection pass, rate after the mean
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= (pass_end && (bit_reg == '0) && (n_reg[0] || pass_reg))
                             || ((state_reg == S_MEAN) && div_done && (med_reg != '0));
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            resets_reg    <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (head.kind)
                            KIND_RECORD:
                            begin
                                stamp_reg <= head.stamp;
                                state_reg <= S_GAP;
                            end
                            KIND_CLEAR:
                            begin
                                first_reg  <= '0;
                                last_reg   <= '0;
                                count_reg  <= '0;
                                sum_reg    <= '0;
                                min_reg    <= '1;
                                max_reg    <= '0;
                                resets_reg <= '0;
                                ovf_reg    <= 1'b0;
                            end
                            KIND_REPORT:
                            begin
                                n_reg      <= n_comb;
                                med_reg    <= '0;
                                mean_reg   <= '0;
                                rate_reg   <= '0;
                                k_reg      <= n_comb[0] ? (n_comb >> 1)
                                                        : (n_comb >> 1) - 1'b1;
                                prefix_reg <= '0;
                                himask_reg <= '0;
                                bit_reg    <= 5'd31;
                                iss_reg    <= '0;
                                c_reg      <= '0;
                                pass_reg   <= 1'b0;
                                state_reg  <= (n_comb == '0) ? S_OUT : S_SEL;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_GAP:
                begin
                    zero_reg  <= stamp_reg == '0;
                    gt_reg    <= stamp_reg > last_reg;
                    lt_reg    <= stamp_reg < last_reg;
                    gap_reg   <= (|gap_full[TS_W-1:DELTA_W]) ? '1 : gap_full[DELTA_W-1:0];
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (!zero_reg)
                    begin
                        if ((count_reg == '0) || (lt_reg && !gt_reg))
                        begin
                            // start a new series with this stamp
                            if (count_reg != '0 && resets_reg != '1)
                            begin
                                resets_reg <= resets_reg + 1'b1;
                            end
                            first_reg <= stamp_reg;
                            last_reg  <= stamp_reg;
                            count_reg <= CW'(1);
                            sum_reg   <= '0;
                            min_reg   <= '1;
                            max_reg   <= '0;
                        end
                        else if (gt_reg)
                        begin
                            if (count_reg >= CW'(MAX_SAMPLES))
                            begin
                                ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                sum_reg   <= sum_reg + SW'(gap_reg);
                                if (gap_reg < min_reg)
                                begin
                                    min_reg <= gap_reg;
                                end
                                if (gap_reg > max_reg)
                                begin
                                    max_reg <= gap_reg;
                                end
                                last_reg  <= stamp_reg;
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                    state_reg <= S_IDLE;
                end
                S_SEL:
                begin
                    if (ram_re)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    pend_reg <= ram_re;
                    if (pend_reg && match)
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                    if (pass_end)
                    begin
                        iss_reg <= '0;
                        c_reg   <= '0;
                        if (bit_reg == '0)
                        begin
                            prefix_reg <= '0;
                            himask_reg <= '0;
                            bit_reg    <= 5'd31;
                            if (n_reg[0])
                            begin
                                med_reg   <= {sel_val, 1'b0};
                                state_reg <= S_MEAN;
                            end
                            else if (!pass_reg)
                            begin
                                sel_a_reg <= sel_val;
                                pass_reg  <= 1'b1;
                                k_reg     <= n_reg >> 1;
                            end
                            else
                            begin
                                med_reg   <= {1'b0, sel_a_reg} + {1'b0, sel_val};
                                state_reg <= S_MEAN;
                            end
                        end
                        else
                        begin
                            prefix_reg <= sel_val;
                            if (take_one)
                            begin
                                k_reg <= k_reg - c_reg;
                            end
                            bit_reg    <= bit_reg - 1'b1;
                            himask_reg <= {1'b1, himask_reg[DELTA_W-1:1]};
                        end
                    end
                end
                S_MEAN:
                begin
                    if (div_done)
                    begin
                        mean_reg <= div_quo[39:0];
                        if (med_reg != '0)
                        begin
                            state_reg <= S_RATE;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_RATE:
                begin
                    if (div_done)
                    begin
                        rate_reg  <= div_quo[29:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            result_reg.sample_count    <= 11'(count_reg);
            result_reg.first_time      <= first_reg;
            result_reg.last_time       <= last_reg;
            result_reg.delta_count     <= 10'(n_reg);
            result_reg.min_delta       <= (n_reg != '0) ? min_reg : '0;
            result_reg.max_delta       <= (n_reg != '0) ? max_reg : '0;
            result_reg.mean_delta      <= mean_reg;
            result_reg.median_delta    <= med_reg;
            result_reg.rate_millihertz <= rate_reg;
            result_reg.rate_valid      <= (n_reg != '0) && (med_reg != '0);
            result_reg.reset_total     <= resets_reg;
            result_reg.overflowed      <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
`default_nettype wire

// File: hdl/vblank_interval_statistics.sv
// ----------------------------------------------------------------------------
// vblank_interval_statistics
// Interval statistics over a series of vblank timestamps.
// ----------------------------------------------------------------------------
// A record transaction passes through the execution unit as the pop, gap and
// update states; a queue of four commands lets the input run ahead of it. A
// report runs a bitwise median selection over the n stored intervals (two
// selections for even n), one pass over the store per bit, each pass set by
// the single read port of the delta store, then uses the shared bit-serial
// divider for the mean and the rate, between the pop and output states. A
// clear is done in the pop state. Reports only start once the previous result
// has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "vblank_interval_statistics_macros.svh"
module vblank_interval_statistics #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,  // timestamp
    input  wire logic [1:0]   s_axis_tuser,  // op
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // sample_count, first_time, last_time, delta_count, min_delta, max_delta,
    // mean_delta, median_delta, rate_millihertz, rate_valid, reset_total,
    // overflowed, two zero pad bits
    output logic      [351:0] m_axis_tdata
);

    import vis_pkg::*;

    logic    head_valid;
    cmd_t    head;
    logic    pop;
    result_t result;

    vis_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .pop          (pop),
        .head_valid   (head_valid),
        .head         (head)
    );

    vis_back #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // output packing, first field lowest
    assign m_axis_tdata = {2'b00, result.overflowed, result.reset_total, result.rate_valid,
                           result.rate_millihertz, result.median_delta, result.mean_delta,
                           result.max_delta, result.min_delta, result.delta_count,
                           result.last_time, result.first_time, result.sample_count};

    // checks
    `VIS_ASSERT_IMPL(a_full_has_head, clk, rst_n, !s_axis_tready, head_valid)
    `VIS_ASSERT_IMPL(a_rate_needs_interval, clk, rst_n,
                     m_axis_tvalid && result.rate_valid, result.delta_count != '0)
    `VIS_ASSERT_NEXT(a_report_pop_no_out, clk, rst_n,
                     pop && (head.kind == KIND_REPORT), !m_axis_tvalid)

endmodule
`default_nettype wire
